/* design/ssp_pkg.sv */
// ssp_pkg: shared types, codes and character constants for the size string parser
// no dependencies; imported by size_string_parser and tb

package ssp_pkg;

    // offset counter saturates at the smaller of the character limit and 255
    localparam int MAX_CHARS = 255;
    localparam logic [7:0] OFF_LIMIT = (MAX_CHARS < 255) ? 8'(MAX_CHARS) : 8'd255;

    // configuration register indexes
    localparam logic REG_RADIX     = 1'b0;
    localparam logic REG_SIZE_MODE = 1'b1;

    localparam logic [5:0] RADIX_RESET = 6'd10;
    localparam logic [5:0] RADIX_MIN   = 6'd2;
    localparam logic [5:0] RADIX_MAX   = 6'd36;
    localparam logic [5:0] RADIX_HEX   = 6'd16;

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_X    = 8'h78;

    typedef enum logic [1:0] {
        PH_DIGIT  = 2'd0,
        PH_STOP   = 2'd1,
        PH_SUFFIX = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_DIGITS = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_TRAILING  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        UNIT_ONE = 2'd0,
        UNIT_K   = 2'd1,
        UNIT_M   = 2'd2,
        UNIT_G   = 2'd3
    } unit_t;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } digit_t;

    // alphanumeric character to digit value 0..35
    function automatic digit_t digit_of(input logic [7:0] c);
        digit_t d;
        d.valid = 1'b1;
        d.value = 6'd0;
        if (c inside {[8'h30:8'h39]})
        begin
            d.value = 6'(c - 8'h30);
        end
        else if (c inside {[8'h61:8'h7a]})
        begin
            d.value = 6'(c - 8'h61 + 8'd10);
        end
        else if (c inside {[8'h41:8'h5a]})
        begin
            d.value = 6'(c - 8'h41 + 8'd10);
        end
        else
        begin
            d.valid = 1'b0;
        end
        return d;
    endfunction

    function automatic unit_t suffix_of(input logic [7:0] c);
        unit_t u;
        case (c)
            8'h4b, 8'h6b: u = UNIT_K;
            8'h4d, 8'h6d: u = UNIT_M;
            8'h47, 8'h67: u = UNIT_G;
            default:      u = UNIT_ONE;
        endcase
        return u;
    endfunction

endpackage

/* design/size_string_parser.sv */
// size_string_parser: streaming unsigned number parser with k/m/g size suffix
// depends on ssp_pkg for phase, status and unit codes and character decode
//
//  channel   dir  handshake                tdata / fields (lsb first)
//  s_axis    in   s_tvalid / s_tready      ch[7:0]
//  m_axis    out  m_tvalid / m_tready      parsed_value[63:0], status[65:64],
//                                          end_offset[73:66], zero pad to 80
//  apb       in   psel, penable, pwrite    0x0 radix[5:0], 0x4 size_mode[0]
//
// a character waits in the input register, then one pass of logic (a 64 by 6
// multiply, an add and the overflow checks) updates the parse state; a new character
// is taken every cycle unless a nul is held by a waiting result. a nul's result goes
// to the output register as the nul leaves the input register, which drains while a
// result waits unless it holds a nul; only then does the downstream stall reach s_tready.
// reset clears all parse state and loads radix 10 and size mode on.

module size_string_parser
    import ssp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // character stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // ch[7:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // parsed_value[63:0], status[65:64], end_offset[73:66]
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration registers
    logic [5:0] radix_reg;
    logic       size_mode_reg;

    // input register
    logic       in_valid_reg;
    logic [7:0] ch_reg;

    // parse state
    phase_t      phase_reg, phase_next;
    logic [63:0] accum_reg, accum_next;
    logic [7:0]  char_pos_reg, char_pos_next;
    logic        digits_seen_reg, digits_seen_next;
    logic        first_zero_reg, first_zero_next;
    logic        overflow_reg, overflow_next;
    unit_t       unit_reg, unit_next;
    logic        garbage_reg, garbage_next;
    logic [7:0]  stop_pos_reg, stop_pos_next;

    // result register
    logic        out_valid_reg;
    logic [63:0] value_reg, value_next;
    status_t     status_reg, status_next;
    logic [7:0]  offset_reg, offset_next;

    logic        consume;
    logic        is_nul;
    logic        load_result;
    logic [5:0]  eff_radix;
    digit_t      dig;
    logic [69:0] product;
    logic [64:0] sum;
    logic        mul_ovf;
    logic        hex_skip;
    unit_t       suffix;
    logic        cfg_write;

    // ---------------------------------------------------------------- config port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg     <= RADIX_RESET;
            size_mode_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            // word registers: the two low address bits are ignored
            case (paddr[2])
                REG_RADIX:     radix_reg     <= pwdata[5:0];
                REG_SIZE_MODE: size_mode_reg <= pwdata[0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_RADIX:     prdata = {26'd0, radix_reg};
            REG_SIZE_MODE: prdata = {31'd0, size_mode_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------- flow control
    // a non-nul character never needs the output register, so it always moves on
    assign is_nul      = (ch_reg == CH_NUL);
    assign consume     = in_valid_reg && (!is_nul || !out_valid_reg || m_tready);
    assign load_result = consume && is_nul;
    assign s_tready    = !in_valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            ch_reg <= s_tdata;
        end
    end

    // ---------------------------------------------------------------- digit datapath
    // out-of-range radix clamps to the nearest legal base
    assign eff_radix = (radix_reg < RADIX_MIN) ? RADIX_MIN :
                       (radix_reg > RADIX_MAX) ? RADIX_MAX : radix_reg;

    assign dig = digit_of(ch_reg);

    // accum * r overflows exactly when any of the top six product bits is set
    assign product = 70'(accum_reg) * 70'(eff_radix);
    assign sum     = {1'b0, product[63:0]} + 65'(dig.value);
    assign mul_ovf = (|product[69:64]) || sum[64];

    // "0x" in base 16 drops the leading zero digit
    assign hex_skip = (char_pos_reg == 8'd1) && first_zero_reg && (ch_reg == CH_X)
                      && (eff_radix == RADIX_HEX);

    assign suffix = suffix_of(ch_reg);

    // ---------------------------------------------------------------- next state
    always_comb
    begin
        logic [63:0] scaled;
        logic        scale_ovf;

        phase_next       = phase_reg;
        accum_next       = accum_reg;
        char_pos_next    = char_pos_reg;
        digits_seen_next = digits_seen_reg;
        first_zero_next  = first_zero_reg;
        overflow_next    = overflow_reg;
        unit_next        = unit_reg;
        garbage_next     = garbage_reg;
        stop_pos_next    = stop_pos_reg;
        value_next       = 64'd0;
        status_next      = ST_OK;
        offset_next      = 8'd0;
        scaled           = accum_reg;
        scale_ovf        = 1'b0;

        // suffix scaling, checked against the bits shifted out
        if (size_mode_reg)
        begin
            case (unit_reg)
                UNIT_K:
                begin
                    scale_ovf = |accum_reg[63:54];
                    scaled    = accum_reg << 10;
                end
                UNIT_M:
                begin
                    scale_ovf = |accum_reg[63:44];
                    scaled    = accum_reg << 20;
                end
                UNIT_G:
                begin
                    scale_ovf = |accum_reg[63:34];
                    scaled    = accum_reg << 30;
                end
                default: ;
            endcase
        end

        if (is_nul)
        begin
            // error priority: digit overflow, no digits, scale overflow, trailing
            if (overflow_reg)
            begin
                status_next = ST_OVERFLOW;
            end
            else if (!digits_seen_reg)
            begin
                status_next = ST_NO_DIGITS;
            end
            else if (scale_ovf)
            begin
                status_next = ST_OVERFLOW;
            end
            else if (size_mode_reg && garbage_reg)
            begin
                status_next = ST_TRAILING;
            end
            else
            begin
                value_next  = scaled;
                // still in the digit run: the run ends at the nul itself
                offset_next = (phase_reg == PH_DIGIT) ? char_pos_reg : stop_pos_reg;
            end

            // clear for the next string
            phase_next       = PH_DIGIT;
            accum_next       = 64'd0;
            char_pos_next    = 8'd0;
            digits_seen_next = 1'b0;
            first_zero_next  = 1'b0;
            overflow_next    = 1'b0;
            unit_next        = UNIT_ONE;
            garbage_next     = 1'b0;
            stop_pos_next    = 8'd0;
        end
        else
        begin
            case (phase_reg)
                PH_DIGIT:
                begin
                    if (hex_skip)
                    begin
                        accum_next       = 64'd0;
                        digits_seen_next = 1'b0;
                        first_zero_next  = 1'b0;
                    end
                    else if (dig.valid && (dig.value < eff_radix))
                    begin
                        if (mul_ovf)
                        begin
                            overflow_next = 1'b1;
                            phase_next    = PH_STOP;
                        end
                        else
                        begin
                            accum_next       = sum[63:0];
                            digits_seen_next = 1'b1;
                            if ((char_pos_reg == 8'd0) && (ch_reg == CH_ZERO)
                                && (eff_radix == RADIX_HEX))
                            begin
                                first_zero_next = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        stop_pos_next = char_pos_reg;
                        phase_next    = PH_STOP;
                        if (size_mode_reg)
                        begin
                            if (suffix != UNIT_ONE)
                            begin
                                unit_next  = suffix;
                                phase_next = PH_SUFFIX;
                            end
                            else
                            begin
                                garbage_next = 1'b1;
                            end
                        end
                    end
                end
                PH_SUFFIX:
                begin
                    // anything after the suffix is trailing garbage
                    garbage_next = 1'b1;
                end
                default: ;
            endcase

            if (char_pos_reg < OFF_LIMIT)
            begin
                char_pos_next = char_pos_reg + 8'd1;
            end
        end
    end

    // ---------------------------------------------------------------- state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_DIGIT;
            accum_reg       <= 64'd0;
            char_pos_reg    <= 8'd0;
            digits_seen_reg <= 1'b0;
            first_zero_reg  <= 1'b0;
            overflow_reg    <= 1'b0;
            unit_reg        <= UNIT_ONE;
            garbage_reg     <= 1'b0;
            stop_pos_reg    <= 8'd0;
        end
        else if (consume)
        begin
            phase_reg       <= phase_next;
            accum_reg       <= accum_next;
            char_pos_reg    <= char_pos_next;
            digits_seen_reg <= digits_seen_next;
            first_zero_reg  <= first_zero_next;
            overflow_reg    <= overflow_next;
            unit_reg        <= unit_next;
            garbage_reg     <= garbage_next;
            stop_pos_reg    <= stop_pos_next;
        end
    end

    // ---------------------------------------------------------------- result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            value_reg  <= value_next;
            status_reg <= status_next;
            offset_reg <= offset_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, offset_reg, status_reg, value_reg};

    // ---------------------------------------------------------------- assertions
    // a consumed nul always leaves a result waiting in the next cycle
    a_nul_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        load_result |=> out_valid_reg)
        else $error("nul consumed without a result");

    // errors carry a zero value and offset
    a_error_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != ST_OK)) |-> ((value_reg == 64'd0)
        && (offset_reg == 8'd0)))
        else $error("error result with non-zero payload");

    // digit overflow always ends the digit run
    a_ovf_stops: assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg |-> (phase_reg != PH_DIGIT))
        else $error("overflow seen while still in digit phase");

    // the suffix phase is only entered with a real unit
    a_suffix_unit: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SUFFIX) |-> (unit_reg != UNIT_ONE))
        else $error("suffix phase without a unit");

endmodule

/* tb/tb.sv */
// tb: self-checking testbench for size_string_parser, strings in, one parsed result per nul out
// depends on ssp_pkg for status and unit codes, register indexes and the offset limit
`timescale 1ns / 1ps

module tb;
    import ssp_pkg::*;

    // one parsed result as it leaves the block
    typedef struct {
        logic [63:0] value;
        status_t     status;
        logic [7:0]  offset;
    } parse_result_t;

    // directed stimulus: a string (nul added on send), the setting it runs under,
    // a number of leading zeros to pad with, and optionally a hand-written result
    typedef struct {
        string       text;
        int          radix;
        bit          size_mode;
        int          pad_zeros;
        bit          typed;
        logic [63:0] value;
        status_t     status;
        logic [7:0]  offset;
    } string_case_t;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int ITEM_TARGET    = 1050;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // ch[7:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;     // parsed_value[63:0], status[65:64], end_offset[73:66]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    size_string_parser uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    // register copies as the parser sees them
    logic [5:0] cfg_radix;
    logic       cfg_size_mode;

    // parse state of the predictor
    phase_t      phase;
    logic [63:0] accum;
    logic [7:0]  char_pos;
    logic        digits_seen;
    logic        first_was_zero;
    logic        overflow_seen;
    unit_t       unit;
    logic        garbage_seen;
    logic [7:0]  stop_pos;

    parse_result_t pending_results[$];

    int err_count;
    int char_count;
    int string_count;
    int result_count;
    int setting_count;
    int idle_cycles;
    int rx_hold;
    bit tx_idle_on;
    bit rx_idle_on;

    // radix register outside 2..36 is clamped
    function automatic int clamp_radix(input logic [5:0] reg_val);
        if (reg_val < RADIX_MIN)
        begin
            return int'(RADIX_MIN);
        end
        if (reg_val > RADIX_MAX)
        begin
            return int'(RADIX_MAX);
        end
        return int'(reg_val);
    endfunction

    // alphanumeric value 0..35, anything else well out of any base
    function automatic int char_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9")
        begin
            return c - "0";
        end
        if (c >= "a" && c <= "z")
        begin
            return c - "a" + 10;
        end
        if (c >= "A" && c <= "Z")
        begin
            return c - "A" + 10;
        end
        return 99;
    endfunction

    function automatic unit_t char_unit(input logic [7:0] c);
        if (c == "k" || c == "K")
        begin
            return UNIT_K;
        end
        if (c == "m" || c == "M")
        begin
            return UNIT_M;
        end
        if (c == "g" || c == "G")
        begin
            return UNIT_G;
        end
        return UNIT_ONE;
    endfunction

    function automatic void clear_parse_state();
        phase          = PH_DIGIT;
        accum          = '0;
        char_pos       = '0;
        digits_seen    = 1'b0;
        first_was_zero = 1'b0;
        overflow_seen  = 1'b0;
        unit           = UNIT_ONE;
        garbage_seen   = 1'b0;
        stop_pos       = '0;
    endfunction

    // advance the parse by one character; returns 1 with the result when c is a nul
    function automatic bit parse_char(input logic [7:0] c, output parse_result_t res);
        int          r;
        int          d;
        int          sh;
        logic [70:0] wide;
        logic [63:0] v;
        unit_t       u;
        r = clamp_radix(cfg_radix);
        res.value  = '0;
        res.status = ST_OK;
        res.offset = '0;
        if (c == CH_NUL)
        begin
            if (phase == PH_DIGIT)
            begin
                stop_pos = char_pos;
            end
            if (overflow_seen)
            begin
                res.status = ST_OVERFLOW;
            end
            else if (!digits_seen)
            begin
                res.status = ST_NO_DIGITS;
            end
            else
            begin
                v = accum;
                if (cfg_size_mode && unit != UNIT_ONE)
                begin
                    sh = 10 * int'(unit);
                    if ((v >> (64 - sh)) != 0)
                    begin
                        res.status = ST_OVERFLOW;
                    end
                    else
                    begin
                        v = v << sh;
                    end
                end
                if (res.status == ST_OK && cfg_size_mode && garbage_seen)
                begin
                    res.status = ST_TRAILING;
                end
                if (res.status == ST_OK)
                begin
                    res.value  = v;
                    res.offset = stop_pos;
                end
            end
            clear_parse_state();
            return 1'b1;
        end
        if (phase == PH_DIGIT)
        begin
            d = char_digit(c);
            if (char_pos == 8'd1 && first_was_zero && c == CH_X && r == RADIX_HEX)
            begin
                // "0x" prefix: the zero was not a digit after all
                accum          = '0;
                digits_seen    = 1'b0;
                first_was_zero = 1'b0;
            end
            else if (d < r)
            begin
                // multiply-add carried wide: any bit above 63 is an overflow
                wide = 71'(accum) * 71'(r) + 71'(d);
                if (wide[70:64] != '0)
                begin
                    overflow_seen = 1'b1;
                    phase         = PH_STOP;
                end
                else
                begin
                    accum       = wide[63:0];
                    digits_seen = 1'b1;
                    if (char_pos == 8'd0 && c == CH_ZERO && r == RADIX_HEX)
                    begin
                        first_was_zero = 1'b1;
                    end
                end
            end
            else
            begin
                stop_pos = char_pos;
                phase    = PH_STOP;
                if (cfg_size_mode)
                begin
                    u = char_unit(c);
                    if (u != UNIT_ONE)
                    begin
                        unit  = u;
                        phase = PH_SUFFIX;
                    end
                    else
                    begin
                        garbage_seen = 1'b1;
                    end
                end
            end
        end
        else if (phase == PH_SUFFIX)
        begin
            garbage_seen = 1'b1;
        end
        if (char_pos < OFF_LIMIT)
        begin
            char_pos = char_pos + 8'd1;
        end
        return 1'b0;
    endfunction

    // one character transfer; the prediction is made at the accepting edge
    task automatic send_char(input logic [7:0] c, input bit typed, input parse_result_t typed_res);
        int            gap;
        parse_result_t res;
        gap = tx_idle_on ? $urandom_range(0, 14) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        char_count++;
        if (parse_char(c, res))
        begin
            string_count++;
            pending_results.push_back(typed ? typed_res : res);
        end
    endtask

    task automatic send_chars(input logic [7:0] chars[$], input bit typed,
                              input parse_result_t typed_res);
        foreach (chars[i])
        begin
            send_char(chars[i], 1'b0, typed_res);
        end
        send_char(CH_NUL, typed, typed_res);
    endtask

    // sender holds off until the result stream has drained and the block is quiet
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        if (addr == {REG_RADIX, 2'b00})
        begin
            cfg_radix = data[5:0];
        end
        else
        begin
            cfg_size_mode = data[0];
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_check_read(input logic [2:0] addr, input logic [31:0] expected);
        logic [31:0] got;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        got = prdata;
        if (got !== expected)
        begin
            $error("prdata at 0x%0h: expected 0x%0h, got 0x%0h", addr, expected, got);
            err_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // new setting: only written once every result is out; upper data bits are noise
    task automatic set_config(input int radix_val, input bit mode_val);
        logic [31:0] data;
        settle();
        data      = $urandom;
        data[5:0] = 6'(radix_val);
        apb_write({REG_RADIX, 2'b00}, data);
        data    = $urandom;
        data[0] = mode_val;
        apb_write({REG_SIZE_MODE, 2'b00}, data);
        apb_check_read({REG_RADIX, 2'b00}, {26'd0, cfg_radix});
        apb_check_read({REG_SIZE_MODE, 2'b00}, {31'd0, cfg_size_mode});
        setting_count++;
    endtask

    // random string: mostly digits of the current base with optional prefix, suffix
    // and trailing junk, some runs of the top digit around the 64-bit limit, some noise
    task automatic random_string();
        logic [7:0]    chars[$];
        parse_result_t none;
        logic [70:0]   pw;
        int            r;
        int            kind;
        int            n;
        int            n_fit;
        int            d;
        string         units;
        r     = clamp_radix(cfg_radix);
        kind  = $urandom_range(0, 99);
        none  = '{default: '0, status: ST_OK};
        units = "kKmMgG";
        pw    = 71'd1;
        n_fit = 0;
        while (pw * 71'(r) <= {7'd1, 64'd0})
        begin
            pw = pw * 71'(r);
            n_fit++;
        end
        if (kind < 15)
        begin
            n = $urandom_range(0, 8);
            repeat (n) chars.push_back(8'($urandom_range(1, 255)));
        end
        else
        begin
            if (r == RADIX_HEX && $urandom_range(0, 2) == 0)
            begin
                chars.push_back(CH_ZERO);
                chars.push_back(CH_X);
            end
            if (kind < 35)
            begin
                n = $urandom_range(n_fit - 1, n_fit + 1);
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(0, n_fit + 1);
            end
            else
            begin
                n = $urandom_range(1, 6);
            end
            for (int i = 0; i < n; i++)
            begin
                d = $urandom_range(0, r - 1);
                if (kind < 35 && $urandom_range(0, 4) != 0)
                begin
                    d = r - 1;
                end
                if (d < 10)
                begin
                    chars.push_back(8'("0" + d));
                end
                else
                begin
                    chars.push_back(8'(($urandom_range(0, 1) ? "a" : "A") + d - 10));
                end
            end
            if (cfg_size_mode)
            begin
                if ($urandom_range(0, 99) < 45)
                begin
                    chars.push_back(units[$urandom_range(0, 5)]);
                end
                if ($urandom_range(0, 9) == 0)
                begin
                    chars.push_back(8'($urandom_range(1, 255)));
                end
            end
            else if ($urandom_range(0, 9) < 3)
            begin
                n = $urandom_range(1, 4);
                repeat (n) chars.push_back(8'($urandom_range(1, 255)));
            end
        end
        send_chars(chars, 1'b0, none);
    endtask

    // hand-picked strings; a result is typed in where it is plain from the rules
    string_case_t string_cases [] = '{
        // straight after reset: base 10, size mode on
        '{"123", 10, 1, 0, 1, 64'd123, ST_OK, 8'd3},
        '{"", 10, 1, 0, 1, 64'd0, ST_NO_DIGITS, 8'd0},
        '{"4k", 10, 1, 0, 1, 64'd4096, ST_OK, 8'd1},
        '{"2M", 10, 1, 0, 1, 64'd2097152, ST_OK, 8'd1},
        '{"3g", 10, 1, 0, 1, 64'd3221225472, ST_OK, 8'd1},
        '{"18446744073709551615", 10, 1, 0, 1, 64'hffff_ffff_ffff_ffff, ST_OK, 8'd20},
        '{"18446744073709551616", 10, 1, 0, 1, 64'd0, ST_OVERFLOW, 8'd0},
        '{"99999999999999999999k", 10, 1, 0, 1, 64'd0, ST_OVERFLOW, 8'd0},
        '{"17179869184G", 10, 1, 0, 1, 64'd0, ST_OVERFLOW, 8'd0},
        '{"17179869183G", 10, 1, 0, 0, 64'd0, ST_OK, 8'd0},
        '{"5kb", 10, 1, 0, 1, 64'd0, ST_TRAILING, 8'd0},
        '{"12#", 10, 1, 0, 1, 64'd0, ST_TRAILING, 8'd0},
        '{"k", 10, 1, 0, 1, 64'd0, ST_NO_DIGITS, 8'd0},
        '{"\377", 10, 1, 0, 1, 64'd0, ST_NO_DIGITS, 8'd0},
        // long run of zeros: offset pins at its limit
        '{"7k", 10, 1, 260, 0, 64'd0, ST_OK, 8'd0},
        // plain mode ignores whatever follows the digits
        '{"42abc", 10, 0, 0, 1, 64'd42, ST_OK, 8'd2},
        '{"1k", 10, 0, 0, 1, 64'd1, ST_OK, 8'd1},
        '{"7 8", 10, 0, 0, 1, 64'd7, ST_OK, 8'd1},
        '{"", 10, 0, 300, 1, 64'd0, ST_OK, 8'd255},
        // hex prefix handling
        '{"0x", 16, 0, 0, 1, 64'd0, ST_NO_DIGITS, 8'd0},
        '{"0x1F", 16, 1, 0, 1, 64'd31, ST_OK, 8'd4},
        '{"0", 16, 1, 0, 1, 64'd0, ST_OK, 8'd1},
        '{"0X1", 16, 1, 0, 1, 64'd0, ST_TRAILING, 8'd0},
        '{"10x", 16, 1, 0, 1, 64'd0, ST_TRAILING, 8'd0},
        '{"0xg", 16, 1, 0, 1, 64'd0, ST_NO_DIGITS, 8'd0},
        '{"0xffffffffffffffff", 16, 1, 0, 1, 64'hffff_ffff_ffff_ffff, ST_OK, 8'd18},
        // base extremes, in range and clamped
        '{"zZ", 36, 1, 0, 1, 64'd1295, ST_OK, 8'd2},
        '{"101k", 2, 1, 0, 1, 64'd5120, ST_OK, 8'd3},
        '{"1012", 0, 0, 0, 1, 64'd5, ST_OK, 8'd3},
        '{"z", 63, 0, 0, 1, 64'd35, ST_OK, 8'd1}
    };

    // result side: stall draw after each transfer, then hold ready low for that long
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            m_tready <= 1'b0;
            rx_hold = rx_hold - 1;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // compare every result transfer with the oldest prediction
    always @(posedge clk)
    begin
        parse_result_t exp_res;
        if (rst_n && m_tvalid && m_tready)
        begin
            rx_hold = rx_idle_on ? $urandom_range(0, 14) : 0;
            result_count++;
            if (pending_results.size() == 0)
            begin
                $error("result: unexpected transfer, tdata 0x%0h", m_tdata);
                err_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (m_tdata[63:0] !== exp_res.value)
                begin
                    $error("parsed_value: expected %0d, got %0d", exp_res.value, m_tdata[63:0]);
                    err_count++;
                end
                if (m_tdata[65:64] !== exp_res.status)
                begin
                    $error("status: expected %0d, got %0d", exp_res.status, m_tdata[65:64]);
                    err_count++;
                end
                if (m_tdata[73:66] !== exp_res.offset)
                begin
                    $error("end_offset: expected %0d, got %0d", exp_res.offset, m_tdata[73:66]);
                    err_count++;
                end
                if (m_tdata[79:74] !== 6'd0)
                begin
                    $error("pad: expected 0, got 0x%0h", m_tdata[79:74]);
                    err_count++;
                end
            end
        end
    end

    // watchdog: too long without any transfer on any port ends the run
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: %0d results still expected", pending_results.size());
            $display("tb: errors");
            $finish;
        end
    end

    initial
    begin
        logic [7:0]    chars[$];
        parse_result_t typed_res;
        int            n_strings;
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        err_count     = 0;
        char_count    = 0;
        string_count  = 0;
        result_count  = 0;
        setting_count = 0;
        idle_cycles   = 0;
        rx_hold       = 0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        cfg_radix     = RADIX_RESET;
        cfg_size_mode = 1'b1;
        clear_parse_state();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed strings, with a new setting only where the row asks for one
        foreach (string_cases[i])
        begin
            if (string_cases[i].radix != cfg_radix || string_cases[i].size_mode != cfg_size_mode)
            begin
                set_config(string_cases[i].radix, string_cases[i].size_mode);
            end
            chars.delete();
            repeat (string_cases[i].pad_zeros) chars.push_back(CH_ZERO);
            for (int k = 0; k < string_cases[i].text.len(); k++)
            begin
                chars.push_back(string_cases[i].text[k]);
            end
            typed_res.value  = string_cases[i].value;
            typed_res.status = string_cases[i].status;
            typed_res.offset = string_cases[i].offset;
            send_chars(chars, string_cases[i].typed, typed_res);
        end

        // random phases: each under one setting, with or without idling on each side
        while (char_count < ITEM_TARGET)
        begin
            case ($urandom_range(0, 5))
                0:       set_config($urandom_range(0, 63), $urandom_range(0, 1));
                1:       set_config(RADIX_HEX, $urandom_range(0, 1));
                2:       set_config($urandom_range(0, 1) ? RADIX_MIN : RADIX_MAX,
                                    $urandom_range(0, 1));
                default: set_config($urandom_range(2, 36), $urandom_range(0, 1));
            endcase
            tx_idle_on = $urandom_range(0, 3) != 0;
            rx_idle_on = $urandom_range(0, 3) != 0;
            n_strings  = $urandom_range(6, 14);
            repeat (n_strings)
            begin
                if (char_count < ITEM_TARGET)
                begin
                    random_string();
                end
            end
        end

        settle();
        $display("tb: %0d strings parsed, %0d results checked, %0d register settings",
                 string_count, result_count, setting_count);
        $display("tb: bases 0..63 with clamping, size and plain mode, prefix, suffix, overflow");
        if (err_count == 0 && pending_results.size() == 0)
        begin
            $display("tb: clean");
        end
        else
        begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
